@@ rtl/core/urldec_pkg.sv @@
// ----------------------------------------------------------------------------
// urldec_pkg
// Shared types, codes and helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package urldec_pkg;

   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharSpace   = 8'h20;

   localparam int unsigned MaxStringBytes = 65535;
   localparam int unsigned CountCapInt    = (MaxStringBytes < 65535) ? MaxStringBytes : 65535;
   localparam logic [15:0] CountCap       = 16'(CountCapInt);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_HEX   = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_HIGH = 3'b010,
      PHASE_LOW  = 3'b100
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
      logic       in_last;
   } req_beat_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        string_end;
      status_type  status;
      logic [15:0] decoded_length;
   } rsp_beat_type;

   // {digit ok, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0_0000;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

@@ rtl/core/urldec_in_stage.sv @@
// ----------------------------------------------------------------------------
// urldec_in_stage
// Input register: holds one request beat until the decoder consumes it.
// ----------------------------------------------------------------------------
module urldec_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_in_byte,
   input  logic                    req_in_last,
   input  logic                    consume,
   output urldec_pkg::req_beat_type beat
);
   import urldec_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   assign req_ready = !valid_ff || consume;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff <= req_in_byte;
         last_ff <= req_in_last;
      end
   end

   assign beat = '{valid: valid_ff, in_byte: byte_ff, in_last: last_ff};
endmodule

@@ rtl/core/urldec_core.sv @@
// ----------------------------------------------------------------------------
// urldec_core
// Decode state and the per-beat decision: escape phase, high nibble,
// error mark and saturating decoded-byte count.
// ----------------------------------------------------------------------------
module urldec_core (
   input  logic                     clock,
   input  logic                     reset,
   input  urldec_pkg::req_beat_type beat,
   input  logic                     consume,
   output logic                     has_result,
   output urldec_pkg::rsp_beat_type result
);
   import urldec_pkg::*;

   phase_type   phase_ff, phase_in, phase_nx;
   logic [3:0]  nibble_ff, nibble_in, nibble_nx;
   logic        error_ff, error_in, error_nx;
   logic [15:0] count_ff, count_in, count_nx;
   logic [4:0]  hex;
   logic        have;
   logic [7:0]  data;
   status_type  status;

   always_comb begin
      hex      = hex_digit(beat.in_byte);
      phase_nx = phase_ff;
      nibble_nx = nibble_ff;
      error_nx = error_ff;
      count_nx = count_ff;
      have     = 1'b0;
      data     = 8'h00;
      if (!error_ff) begin
         unique case (phase_ff)
            PHASE_IDLE: begin
               if (beat.in_byte == CharPercent) begin
                  phase_nx = PHASE_HIGH;
               end else begin
                  have = 1'b1;
                  data = (beat.in_byte == CharPlus) ? CharSpace : beat.in_byte;
               end
            end
            PHASE_HIGH: begin
               if (!hex[4]) begin
                  error_nx = 1'b1;
                  phase_nx = PHASE_IDLE;
               end else begin
                  nibble_nx = hex[3:0];
                  phase_nx  = PHASE_LOW;
               end
            end
            default: begin
               phase_nx = PHASE_IDLE;
               if (!hex[4]) begin
                  error_nx = 1'b1;
               end else begin
                  have = 1'b1;
                  data = {nibble_ff, hex[3:0]};
               end
            end
         endcase
         if (have && count_ff < CountCap) begin
            count_nx = count_ff + 16'd1;
         end
      end

      priority if (error_nx) begin
         status = STATUS_BAD_HEX;
      end else if (phase_nx != PHASE_IDLE) begin
         status = STATUS_TRUNCATED;
      end else begin
         status = STATUS_OK;
      end

      has_result = have || beat.in_last;
      result.out_byte       = have ? data : 8'h00;
      result.byte_valid     = have;
      result.string_end     = beat.in_last;
      result.status         = beat.in_last ? status : STATUS_OK;
      result.decoded_length = beat.in_last ? count_nx : 16'd0;

      phase_in  = phase_ff;
      nibble_in = nibble_ff;
      error_in  = error_ff;
      count_in  = count_ff;
      if (consume) begin
         if (beat.in_last) begin
            phase_in  = PHASE_IDLE;
            nibble_in = 4'h0;
            error_in  = 1'b0;
            count_in  = 16'd0;
         end else begin
            phase_in  = phase_nx;
            nibble_in = nibble_nx;
            error_in  = error_nx;
            count_in  = count_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_IDLE;
         nibble_ff <= 4'h0;
         error_ff  <= 1'b0;
         count_ff  <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         nibble_ff <= nibble_in;
         error_ff  <= error_in;
         count_ff  <= count_in;
      end
   end
endmodule

@@ rtl/core/url_percent_decoder_top.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// URL percent decoder: plain bytes pass, plus becomes space, %XX becomes one
// byte; the last beat of a string carries status and decoded length.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | in_byte, in_last
//   rsp     | out       | rsp_valid/rsp_ready  | out_byte, byte_valid,
//           |           |                      | string_end, status, length
//
// One beat per cycle while rsp does not stall; each req beat passes the input
// register, then the result register. Beats that give no result
// (a percent sign, the first hex digit, data after an error) are dropped
// in the input register stage without using the result register.
// A stall on rsp holds the result register; the input register keeps taking
// beats while the pending beat can still be consumed.
// Synchronous reset clears the valid flags and the decode state.
// ----------------------------------------------------------------------------
module url_percent_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_string_end,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_decoded_length
);
   import urldec_pkg::*;

   req_beat_type beat;
   rsp_beat_type result;
   rsp_beat_type out_ff;
   logic         out_valid_ff, out_valid_in;
   logic         has_result;
   logic         out_free;
   logic         consume;

   assign out_free = !out_valid_ff || rsp_ready;
   assign consume  = beat.valid && (out_free || !has_result);

   urldec_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .consume     (consume),
      .beat        (beat)
   );

   urldec_core u_core (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .consume    (consume),
      .has_result (has_result),
      .result     (result)
   );

   assign out_valid_in = out_free ? (consume && has_result) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && consume && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_ff.out_byte;
   assign rsp_byte_valid     = out_ff.byte_valid;
   assign rsp_string_end     = out_ff.string_end;
   assign rsp_status         = out_ff.status;
   assign rsp_decoded_length = out_ff.decoded_length;
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for url_percent_decoder_top. A scoreboard class decodes
// every accepted input beat on its own (plain, plus, %XX escapes, bad hex
// digits, cut-short escapes, length saturation) and checks each result beat
// field by field in order. Directed strings come first, then random strings
// that are mostly well-formed, and a long receiver stall.
// ----------------------------------------------------------------------------
module tb;
   import urldec_pkg::*;

   localparam int unsigned RandomBeats = 450;
   localparam int unsigned SqueezeCycles = 200;

   class url_decode_scoreboard;
      phase_type    phase;
      logic [3:0]   upper_nibble;
      logic         bad_digit;
      logic [15:0]  out_count;
      rsp_beat_type expected_decodes[$];
      int unsigned  mismatches;
      int unsigned  beats_in;
      int unsigned  beats_out;
      int unsigned  ends_by_status[3];

      function new();
         clear_string();
         mismatches = 0;
         beats_in = 0;
         beats_out = 0;
         ends_by_status = '{0, 0, 0};
      endfunction

      function void clear_string();
         phase = PHASE_IDLE;
         upper_nibble = 4'h0;
         bad_digit = 1'b0;
         out_count = 16'd0;
      endfunction

      static function bit is_hex(input logic [7:0] c, output logic [3:0] v);
         v = 4'h0;
         if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
            return 1'b1;
         end
         if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = 4'(c[3:0] + 4'd9);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_beat(input logic [7:0] b, input logic last);
         rsp_beat_type r;
         logic [3:0]   nib;
         bit           have;
         r = '0;
         have = 1'b0;
         beats_in++;
         if (!bad_digit) begin
            if (phase == PHASE_IDLE) begin
               if (b == CharPercent) begin
                  phase = PHASE_HIGH;
               end else begin
                  r.out_byte = (b == CharPlus) ? CharSpace : b;
                  have = 1'b1;
               end
            end else if (!is_hex(b, nib)) begin
               bad_digit = 1'b1;
               phase = PHASE_IDLE;
            end else if (phase == PHASE_HIGH) begin
               upper_nibble = nib;
               phase = PHASE_LOW;
            end else begin
               r.out_byte = {upper_nibble, nib};
               have = 1'b1;
               phase = PHASE_IDLE;
            end
            if (have && out_count < CountCap) out_count++;
         end
         if (!have && !last) return;
         r.byte_valid = have;
         r.string_end = last;
         if (last) begin
            if (bad_digit) r.status = STATUS_BAD_HEX;
            else if (phase != PHASE_IDLE) r.status = STATUS_TRUNCATED;
            else r.status = STATUS_OK;
            r.decoded_length = out_count;
            ends_by_status[r.status]++;
            clear_string();
         end
         expected_decodes.push_back(r);
      endfunction

      function void check_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_beat(input logic [7:0] ob, input logic bv, input logic se,
                               input logic [1:0] st, input logic [15:0] len);
         rsp_beat_type e;
         beats_out++;
         if (expected_decodes.size() == 0) begin
            $error("result beat with nothing expected: byte %0h end %0b", ob, se);
            mismatches++;
            return;
         end
         e = expected_decodes.pop_front();
         check_field("out_byte", 16'(e.out_byte), 16'(ob));
         check_field("byte_valid", 16'(e.byte_valid), 16'(bv));
         check_field("string_end", 16'(e.string_end), 16'(se));
         check_field("status", 16'(e.status), 16'(st));
         check_field("decoded_length", e.decoded_length, len);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_string_end;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_decoded_length;

   url_decode_scoreboard sb = new();
   bit gapless = 1'b0;
   bit squeeze = 1'b0;
   int unsigned beats_sent = 0;

   url_percent_decoder_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .req_in_last(req_in_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_string_end(rsp_string_end),
      .rsp_status(rsp_status),
      .rsp_decoded_length(rsp_decoded_length)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_beat(req_in_byte, req_in_last);
         if (rsp_valid && rsp_ready) begin
            sb.check_beat(rsp_out_byte, rsp_byte_valid, rsp_string_end, rsp_status,
                          rsp_decoded_length);
         end
      end
   end

   function automatic int unsigned gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      logic [3:0] v;
      do c = 8'($urandom_range(0, 255));
      while (url_decode_scoreboard::is_hex(c, v));
      return c;
   endfunction

   // receiver: random stalls, long hold on request
   initial begin
      @(negedge reset);
      forever begin
         if (squeeze) begin
            rsp_ready <= 1'b0;
            repeat (SqueezeCycles) @(posedge clock);
            squeeze = 1'b0;
         end else if ($urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
      end
   end

   task automatic drive_beat(input logic [7:0] b, input logic last);
      if (!gapless && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock);
      while (!req_ready);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) drive_beat(s[i], i == s.len() - 1);
   endtask

   task automatic send_random_string(input int unsigned tokens, input bit clean);
      logic [7:0] msg[$];
      logic [7:0] c;
      int unsigned r;
      for (int t = 0; t < tokens; t++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            c = 8'($urandom_range(0, 255));
            if (clean && c == CharPercent) c = CharPlus;
            msg.push_back(c);
         end else if (r < 88) begin
            msg.push_back(CharPercent);
            msg.push_back(hex_char(4'($urandom_range(0, 15))));
            msg.push_back(hex_char(4'($urandom_range(0, 15))));
         end else if (r < 94 && !clean) begin
            msg.push_back(CharPercent);
            if ($urandom_range(0, 1) == 0) msg.push_back(hex_char(4'($urandom_range(0, 15))));
            msg.push_back(($urandom_range(0, 3) == 0) ? CharPercent : non_hex_char());
         end else begin
            msg.push_back(CharPlus);
         end
      end
      if (!clean && $urandom_range(0, 7) == 0) begin
         msg.push_back(CharPercent);
         if ($urandom_range(0, 1) == 0) msg.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      if (msg.size() == 0) msg.push_back(8'($urandom_range(0, 255)));
      foreach (msg[i]) drive_beat(msg[i], i == msg.size() - 1);
   endtask

   initial begin
      int unsigned waited;
      int unsigned target;
      bit squeezed;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      drive_beat(CharPlus, 1'b0);
      drive_beat(8'h00, 1'b0);
      drive_beat(8'hFF, 1'b1);
      send_text("%00%fF%A9");
      send_text("%%x");
      send_text("%4");
      send_text("%");
      send_text("%+");
      send_text("%4G");
      send_text("z");

      target = beats_sent + RandomBeats;
      squeezed = 1'b0;
      while (beats_sent < target) begin
         if (!squeezed && beats_sent > target - RandomBeats / 2) begin
            squeezed = 1'b1;
            gapless = 1'b1;
            squeeze = 1'b1;
            send_random_string(20, 1'b1);
         end else begin
            gapless = ($urandom_range(0, 3) == 0);
            send_random_string(($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                           : $urandom_range(0, 6), 1'b0);
         end
      end
      req_valid <= 1'b0;

      waited = 0;
      while (sb.expected_decodes.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (sb.expected_decodes.size() != 0) begin
         $error("%0d expected result beats never arrived", sb.expected_decodes.size());
      end

      $display("Sent %0d beats, checked %0d result beats; strings ended ok %0d, bad hex %0d,",
               sb.beats_in, sb.beats_out, sb.ends_by_status[STATUS_OK],
               sb.ends_by_status[STATUS_BAD_HEX]);
      $display("cut short %0d; included a %0d-cycle output stall.",
               sb.ends_by_status[STATUS_TRUNCATED], SqueezeCycles);
      if (sb.mismatches == 0 && sb.expected_decodes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ url_percent_decoder_top.f @@
rtl/core/urldec_pkg.sv
rtl/core/urldec_in_stage.sv
rtl/core/urldec_core.sv
rtl/core/url_percent_decoder_top.sv
bench/tb.sv
